// File: rtl/alir_pkg.sv
// Shared definitions for the array list block: field widths, request and
// status codes, and the command and status bundles between controller and datapath.
// No dependencies.
package alir_pkg;

    localparam int REQW = 2;
    localparam int IDXW = 6;
    localparam int VALW = 32;
    localparam int STW  = 2;
    localparam int CNTW = 6;

    localparam int CAPACITY_DEF = 32;

    localparam logic [REQW-1:0] REQ_READ   = 2'd0;
    localparam logic [REQW-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQW-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STW-1:0] ST_DONE      = 2'd0;
    localparam logic [STW-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STW-1:0] ST_FULL      = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic req_load;   // capture the incoming request
        logic decide;     // latch the status and set the sweep pointer
        logic rd_idx;     // read the store at the request index
        logic rd_sweep;   // read the source entry of the current shift step
        logic wr_sweep;   // write the shifted entry
        logic wr_put;     // write the inserted value at the request index
        logic step;       // move the sweep pointer
        logic finish;     // update the count and load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic is_insert;
        logic is_remove;
        logic ok;          // the held request will complete with status done
        logic ins_tail;    // insert at the end, nothing to shift
        logic rem_tail;    // remove of the last element, nothing to shift
        logic sweep_last;  // the current shift step is the final one
    } t_stat;

endpackage

// File: rtl/alir_dpath.sv
// Datapath of the array list: element store, count, request registers,
// shift pointer and result register.
// Depends on alir_pkg.
module alir_dpath #(
    parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  alir_pkg::t_cmd                     i_cmd,
    input  logic        [alir_pkg::REQW-1:0]   i_req_type,
    input  logic        [alir_pkg::IDXW-1:0]   i_index,
    input  logic signed [alir_pkg::VALW-1:0]   i_value,
    output alir_pkg::t_stat                    o_stat,
    output logic signed [alir_pkg::VALW-1:0]   o_read_value,
    output logic        [alir_pkg::STW-1:0]    o_status,
    output logic        [alir_pkg::CNTW-1:0]   o_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > alir_pkg::IDXW) ? CW : alir_pkg::IDXW;

    logic [alir_pkg::VALW-1:0] r_mem [CAPACITY];
    logic [alir_pkg::VALW-1:0] r_rd_data;

    logic [alir_pkg::REQW-1:0] r_req;
    logic [alir_pkg::IDXW-1:0] r_idx;
    logic [alir_pkg::VALW-1:0] r_val;
    logic [alir_pkg::STW-1:0]  r_stat;
    logic [CW-1:0]             r_count;
    logic [AW-1:0]             r_ptr;

    logic [KW-1:0]             idx_k;
    logic [KW-1:0]             count_k;
    logic [KW-1:0]             ptr_k;
    logic [alir_pkg::STW-1:0]  stat_now;
    logic                      rd_en;
    logic                      wr_en;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic [alir_pkg::VALW-1:0] wr_data;
    logic [CW-1:0]             n_count;
    logic [KW-1:0]             n_count_k;
    logic [alir_pkg::VALW-1:0] n_read_value;

    assign idx_k   = KW'(r_idx);
    assign count_k = KW'(r_count);
    assign ptr_k   = KW'(r_ptr);

    // Outcome of the held request against the current count.
    always_comb begin
        case (r_req)
            alir_pkg::REQ_READ: begin
                stat_now = (idx_k < count_k) ? alir_pkg::ST_DONE : alir_pkg::ST_BAD_INDEX;
            end
            alir_pkg::REQ_INSERT: begin
                if (idx_k > count_k) begin
                    stat_now = alir_pkg::ST_BAD_INDEX;
                end else if (count_k >= KW'(CAPACITY)) begin
                    stat_now = alir_pkg::ST_FULL;
                end else begin
                    stat_now = alir_pkg::ST_DONE;
                end
            end
            alir_pkg::REQ_REMOVE: begin
                stat_now = (idx_k < count_k) ? alir_pkg::ST_DONE : alir_pkg::ST_BAD_INDEX;
            end
            default: begin
                stat_now = alir_pkg::ST_BAD_INDEX;
            end
        endcase
    end

    always_comb begin
        o_stat.is_read    = (r_req == alir_pkg::REQ_READ);
        o_stat.is_insert  = (r_req == alir_pkg::REQ_INSERT);
        o_stat.is_remove  = (r_req == alir_pkg::REQ_REMOVE);
        o_stat.ok         = (stat_now == alir_pkg::ST_DONE);
        o_stat.ins_tail   = (idx_k == count_k);
        o_stat.rem_tail   = (KW'(idx_k + KW'(1)) == count_k);
        o_stat.sweep_last = (r_req == alir_pkg::REQ_INSERT) ? (ptr_k == idx_k)
                                                            : (KW'(ptr_k + KW'(2)) == count_k);
    end

    // An insert shifts entries up from the tail, a remove shifts them down.
    always_comb begin
        rd_en = i_cmd.rd_idx | i_cmd.rd_sweep;
        wr_en = i_cmd.wr_sweep | i_cmd.wr_put;
        if (i_cmd.rd_idx) begin
            rd_addr = AW'(idx_k);
        end else if (r_req == alir_pkg::REQ_INSERT) begin
            rd_addr = r_ptr;
        end else begin
            rd_addr = AW'(ptr_k + KW'(1));
        end
        if (i_cmd.wr_put) begin
            wr_addr = AW'(idx_k);
            wr_data = r_val;
        end else begin
            wr_addr = (r_req == alir_pkg::REQ_INSERT) ? AW'(ptr_k + KW'(1)) : r_ptr;
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (r_stat == alir_pkg::ST_DONE) begin
            if (r_req == alir_pkg::REQ_INSERT) begin
                n_count = CW'(r_count + CW'(1));
            end else if (r_req == alir_pkg::REQ_REMOVE) begin
                n_count = CW'(r_count - CW'(1));
            end
        end
        n_count_k = KW'(n_count);
        case (r_req)
            alir_pkg::REQ_READ: begin
                n_read_value = (r_stat == alir_pkg::ST_DONE) ? r_rd_data : '1;
            end
            default: begin
                n_read_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_req_type;
            r_idx <= i_index;
            r_val <= i_value;
        end
        if (i_cmd.decide) begin
            r_stat <= stat_now;
            r_ptr  <= (r_req == alir_pkg::REQ_INSERT) ? AW'(count_k - KW'(1)) : AW'(idx_k);
        end else if (i_cmd.step) begin
            r_ptr <= (r_req == alir_pkg::REQ_INSERT) ? AW'(r_ptr - AW'(1))
                                                     : AW'(r_ptr + AW'(1));
        end
        if (i_cmd.finish) begin
            o_read_value <= n_read_value;
            o_status     <= r_stat;
            o_count      <= n_count_k[alir_pkg::CNTW-1:0];
        end
    end

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_req == alir_pkg::REQ_INSERT && r_stat == alir_pkg::ST_DONE
        |=> r_count == CW'($past(r_count) + CW'(1)))
        else $error("count did not grow after a completed insert");

    a_rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_req == alir_pkg::REQ_REMOVE && r_stat == alir_pkg::ST_DONE
        |=> r_count == CW'($past(r_count) - CW'(1)))
        else $error("count did not shrink after a completed remove");

    a_put_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_put |-> r_req == alir_pkg::REQ_INSERT && r_stat == alir_pkg::ST_DONE)
        else $error("value written for a request that may not insert");

endmodule

// File: rtl/alir_ctrl.sv
// Controller of the array list: sequences decision, shift sweep, the write of
// an inserted value and result handoff, and holds the result valid flag.
// Depends on alir_pkg.
module alir_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  alir_pkg::t_stat i_stat,
    output alir_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (!i_stat.ok) begin
                    n_state = S_FINISH;
                end else if (i_stat.is_read) begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_FINISH;
                end else if (i_stat.is_insert) begin
                    n_state = i_stat.ins_tail ? S_PUT : S_SH_RD;
                end else if (i_stat.is_remove && !i_stat.rem_tail) begin
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SH_RD: begin
                o_cmd.rd_sweep = 1'b1;
                n_state        = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.wr_sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = i_stat.is_insert ? S_PUT : S_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SH_RD;
                end
            end
            S_PUT: begin
                o_cmd.wr_put = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !o_out_valid || !i_out_stall)
        else $error("result register overwritten while a result is stalled");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    a_put_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_put |-> i_stat.is_insert)
        else $error("value written for a request that is not an insert");

endmodule

// File: rtl/array_list_insert_remove_top.sv
// Array list top level: an ordered list of signed 32-bit values with read, insert and remove.
// A request is accepted in idle, then passes through a decide state, a read state and a write
// state for each shifted element, a put state for an insert, and a finish state that registers
// the result once the output register is free. The next request is taken only back in idle.
// Reset clears the count and the result valid flag; the element store is not cleared.

// Depends on alir_pkg, alir_ctrl and alir_dpath.
module array_list_insert_remove_top #(
    parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic        [alir_pkg::REQW-1:0]   i_req_type,
    input  logic        [alir_pkg::IDXW-1:0]   i_index,
    input  logic signed [alir_pkg::VALW-1:0]   i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [alir_pkg::VALW-1:0]   o_read_value,
    output logic        [alir_pkg::STW-1:0]    o_status,
    output logic        [alir_pkg::CNTW-1:0]   o_count
);

    // The controller walks each request through decision, an optional shift
    // sweep and the result handoff. A request is taken only while the
    // controller is idle; a finished result may still wait in the output
    // register while the next request is taken and worked on.
    alir_pkg::t_cmd  cmd;
    alir_pkg::t_stat stat;

    alir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the store, the count and the result register. An
    // insert moves entries up one place starting from the tail, a remove
    // moves them down one place starting just past the removed entry.
    alir_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_req_type),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_stat       (stat),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

endmodule

// File: verif/alir_list_checker.sv
`timescale 1ns / 100ps
// Checker for the array list block: watches the request and result
// channels, keeps a shadow copy of the list, and compares every result
// with its prediction. Depends on alir_pkg.
module alir_list_checker #(
    parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic        [alir_pkg::REQW-1:0] i_req_type,
    input  logic        [alir_pkg::IDXW-1:0] i_index,
    input  logic signed [alir_pkg::VALW-1:0] i_value,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic signed [alir_pkg::VALW-1:0] i_read_value,
    input  logic        [alir_pkg::STW-1:0]  i_status,
    input  logic        [alir_pkg::CNTW-1:0] i_count,
    output int                               o_mismatches,
    output int                               o_pending
);

    localparam logic signed [alir_pkg::VALW-1:0] BAD_READ_VALUE = -1;

    typedef struct packed {
        logic signed [alir_pkg::VALW-1:0] read_value;
        logic [alir_pkg::STW-1:0]         status;
        logic [alir_pkg::CNTW-1:0]        count;
    } t_list_reply;

    logic signed [alir_pkg::VALW-1:0] shadow_store [CAPACITY];
    int                               shadow_len = 0;
    t_list_reply                      awaited_replies [$];
    int                               fails = 0;

    // Applies one request to the shadow list and returns the reply it earns.
    function automatic t_list_reply apply_list_request(
        input logic        [alir_pkg::REQW-1:0] rq,
        input logic        [alir_pkg::IDXW-1:0] ix,
        input logic signed [alir_pkg::VALW-1:0] v
    );
        t_list_reply r;
        int pos;
        int j;
        pos          = ix;
        r.read_value = '0;
        r.status     = alir_pkg::ST_DONE;
        case (rq)
            alir_pkg::REQ_READ: begin
                if (pos < shadow_len) begin
                    r.read_value = shadow_store[pos];
                end else begin
                    r.read_value = BAD_READ_VALUE;
                    r.status     = alir_pkg::ST_BAD_INDEX;
                end
            end
            alir_pkg::REQ_INSERT: begin
                // The index check takes priority over the full check.
                if (pos > shadow_len) begin
                    r.status = alir_pkg::ST_BAD_INDEX;
                end else if (shadow_len >= CAPACITY) begin
                    r.status = alir_pkg::ST_FULL;
                end else begin
                    for (j = shadow_len; j > pos; j--) shadow_store[j] = shadow_store[j-1];
                    shadow_store[pos] = v;
                    shadow_len++;
                end
            end
            alir_pkg::REQ_REMOVE: begin
                if (pos >= shadow_len) begin
                    r.status = alir_pkg::ST_BAD_INDEX;
                end else begin
                    for (j = pos; j + 1 < shadow_len; j++) shadow_store[j] = shadow_store[j+1];
                    shadow_len--;
                end
            end
            default: begin
                r.status = alir_pkg::ST_BAD_INDEX;
            end
        endcase
        r.count = alir_pkg::CNTW'(shadow_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_reply want;
        if (!i_rst_n) begin
            shadow_len = 0;
            awaited_replies.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                awaited_replies.push_back(apply_list_request(i_req_type, i_index, i_value));
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("result with no request waiting: read_value %0d status %0d count %0d",
                           i_read_value, i_status, i_count);
                    fails++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d", want.read_value, i_read_value);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, i_count);
                        fails++;
                    end
                end
            end
        end
        o_mismatches <= fails;
        o_pending    <= awaited_replies.size();
    end

endmodule

// File: verif/array_list_insert_remove_top_test.sv
`timescale 1ns / 100ps
// Top of the array list testbench: clock, reset, request stimulus with random
// idling on both channels, and the verdict. Depends on alir_pkg, the block
// array_list_insert_remove_top and the checker alir_list_checker.
module array_list_insert_remove_top_test;

    // Request code the block does not define; it must be refused.
    localparam logic [alir_pkg::REQW-1:0] REQ_UNUSED = 2'd3;

    // The slowest request shifts a full list. The limit is several times the
    // slowest correct run of about 800 requests.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_CYCLES = 100;
    localparam int BLOCKS        = 6;
    localparam int BLOCK_ITEMS   = 125;

    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_in_valid   = 1'b0;
    logic        [alir_pkg::REQW-1:0] i_req_type   = '0;
    logic        [alir_pkg::IDXW-1:0] i_index      = '0;
    logic signed [alir_pkg::VALW-1:0] i_value      = '0;
    logic                             i_out_stall  = 1'b0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    logic signed [alir_pkg::VALW-1:0] o_read_value;
    logic        [alir_pkg::STW-1:0]  o_status;
    logic        [alir_pkg::CNTW-1:0] o_count;

    int   mismatches;
    int   pending;
    int   cycle_count = 0;
    int   list_len    = 0;   // length the list will have once all sent requests complete
    logic idle_on     = 1'b1;

    always #6 i_clk = ~i_clk;

    array_list_insert_remove_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    alir_list_checker list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_read_value (o_read_value),
        .i_status     (o_status),
        .i_count      (o_count),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // The result side stalls at random, with a chance of 19 in a hundred, while idling is on.
    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 19);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Presents one request, with an optional random gap ahead of it, and
    // returns at the edge where the block accepts it. Valid stays high
    // whenever the next request follows without a gap.
    task automatic send_request(
        input logic        [alir_pkg::REQW-1:0] rq,
        input logic        [alir_pkg::IDXW-1:0] ix,
        input logic signed [alir_pkg::VALW-1:0] v
    );
        while (idle_on && ($urandom_range(99) < 19)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rq;
        i_index    <= ix;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // Track the length only to aim indexes at the live part of the list.
        if (rq == alir_pkg::REQ_INSERT && ix <= list_len
                && list_len < alir_pkg::CAPACITY_DEF) begin
            list_len++;
        end else if (rq == alir_pkg::REQ_REMOVE && ix < list_len) begin
            list_len--;
        end
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [alir_pkg::VALW-1:0] pick_value();
        logic signed [alir_pkg::VALW-1:0] v;
        v = $urandom();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: v = 32'sh7fffffff;
                1: v = 32'sh80000000;
                2: v = -1;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    // One random request. Most are well formed and aimed at the ends or the
    // inside of the list; the rest take any code and a wild index. A grow
    // phase favors inserts so that the list fills up and full inserts occur.
    task automatic send_random_request(input bit grow);
        int roll;
        int top_ix;
        logic [alir_pkg::REQW-1:0] rq;
        logic [alir_pkg::IDXW-1:0] ix;
        roll = $urandom_range(99);
        if (roll < 12) begin
            rq = alir_pkg::REQW'($urandom_range(3));
            ix = alir_pkg::IDXW'($urandom_range(63));
        end else begin
            roll = $urandom_range(99);
            if (grow) begin
                rq = (roll < 60) ? alir_pkg::REQ_INSERT
                   : (roll < 80) ? alir_pkg::REQ_REMOVE : alir_pkg::REQ_READ;
            end else begin
                rq = (roll < 15) ? alir_pkg::REQ_INSERT
                   : (roll < 75) ? alir_pkg::REQ_REMOVE : alir_pkg::REQ_READ;
            end
            top_ix = (rq == alir_pkg::REQ_INSERT) ? list_len : list_len - 1;
            if (top_ix < 0) top_ix = 0;
            case ($urandom_range(3))
                0: ix = '0;
                1: ix = alir_pkg::IDXW'(top_ix);
                default: ix = alir_pkg::IDXW'($urandom_range(top_ix));
            endcase
        end
        send_request(rq, ix, pick_value());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the empty list first, then a small list built at
        // both ends and in the middle with the extreme values.
        send_request(alir_pkg::REQ_READ,   6'd0,  32'sd5);
        send_request(alir_pkg::REQ_READ,   6'd63, 32'sd5);
        send_request(alir_pkg::REQ_REMOVE, 6'd0,  32'sd5);
        send_request(alir_pkg::REQ_INSERT, 6'd1,  32'sd9);            // past the end
        send_request(alir_pkg::REQ_INSERT, 6'd63, 32'sd9);
        send_request(alir_pkg::REQ_INSERT, 6'd0,  32'sh7fffffff);
        send_request(alir_pkg::REQ_INSERT, 6'd1,  32'sh80000000);     // at the tail
        send_request(alir_pkg::REQ_INSERT, 6'd1,  -32'sd1);           // in the middle
        send_request(alir_pkg::REQ_INSERT, 6'd0,  32'sd0);            // at the head
        send_request(alir_pkg::REQ_INSERT, 6'd4,  32'sh55555555);
        send_request(alir_pkg::REQ_INSERT, 6'd2,  32'shaaaaaaaa);
        send_request(alir_pkg::REQ_READ,   6'd0,  32'sd0);
        send_request(alir_pkg::REQ_READ,   6'd5,  32'sd0);
        send_request(alir_pkg::REQ_READ,   6'd6,  32'sd0);            // one past the end
        send_request(alir_pkg::REQ_READ,   6'd63, 32'sd0);
        send_request(REQ_UNUSED,           6'd63, -32'sd1);
        send_request(REQ_UNUSED,           6'd0,  32'sd0);
        send_request(alir_pkg::REQ_REMOVE, 6'd0,  32'sd0);            // first
        send_request(alir_pkg::REQ_REMOVE, 6'd4,  32'sd0);            // last
        send_request(alir_pkg::REQ_REMOVE, 6'd1,  32'sd0);            // middle
        send_request(alir_pkg::REQ_REMOVE, 6'd3,  32'sd0);            // at the count
        send_request(alir_pkg::REQ_INSERT, 6'd4,  32'sd1);            // past the count
        send_request(alir_pkg::REQ_READ,   6'd2,  32'sd0);
        send_request(alir_pkg::REQ_REMOVE, 6'd63, 32'sd0);
        drain_results();

        // Random part in blocks that alternate between growing and shrinking
        // the list. One block runs with no idling on either side. After each
        // block the sender holds off until the block has answered everything.
        for (int blk = 0; blk < BLOCKS; blk++) begin
            idle_on <= (blk != 2);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                send_random_request(blk % 2 == 0);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: array_list_insert_remove_top.f
rtl/alir_pkg.sv
rtl/alir_dpath.sv
rtl/alir_ctrl.sv
rtl/array_list_insert_remove_top.sv
verif/alir_list_checker.sv
verif/array_list_insert_remove_top_test.sv
